@@ hw/rtl/hpss_pkg.sv @@
// Shared types, constants and the per-position judging function of the start code scanner.
package hpss_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_STOP = 1'b1;

    localparam logic [7:0] NAL_SPS = 8'h67;
    localparam logic [7:0] NAL_PPS = 8'h68;
    localparam logic [7:0] NAL_SEI = 8'h06;
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_MARK = 8'h01;

    localparam logic [2:0] SKIP_AFTER_MATCH = 3'd4;
    localparam int WIN_DEPTH = 4;
    localparam int NUM_JUDGE = 5;
    localparam int NUM_UNITS = 3;
    localparam int OUT_BITS = 20;
    localparam int LEN_IN_BITS = 20;

    localparam int UNIT_SPS = 0;
    localparam int UNIT_PPS = 1;
    localparam int UNIT_SEI = 2;
    localparam int UNIT_SLICE = 3;

    typedef struct packed {
        logic                   operation;
        logic [7:0]             data_byte;
        logic                   first_of_buffer;
        logic                   last_of_buffer;
        logic [LEN_IN_BITS-1:0] buffer_length;
    } t_item;

    typedef struct packed {
        logic                sps_found;
        logic [OUT_BITS-1:0] sps_offset;
        logic [OUT_BITS-1:0] sps_length;
        logic                pps_found;
        logic [OUT_BITS-1:0] pps_offset;
        logic [OUT_BITS-1:0] pps_length;
        logic                sei_found;
        logic [OUT_BITS-1:0] sei_offset;
        logic [OUT_BITS-1:0] sei_length;
        logic                slice_found;
        logic [OUT_BITS-1:0] slice_offset;
        logic                recording;
    } t_result;

    typedef struct packed {
        logic       stopped;
        logic [2:0] skip;
        logic [3:0] flags;
    } t_ctl;

    typedef struct packed {
        t_ctl       ctl;
        logic [2:0] bump;
        logic [3:0] hit;
    } t_judge;

    // Judges one scan position: skip handling, first-hit capture, length counting and stop.
    function automatic t_judge judge_step(t_ctl ctl_in, logic active, logic sc,
                                          logic [7:0] hdr);
        t_judge j;
        logic   done;
        j.ctl  = ctl_in;
        j.bump = '0;
        j.hit  = '0;
        done   = 1'b0;
        if (active && !ctl_in.stopped) begin
            if (ctl_in.skip != 3'd0) begin
                j.ctl.skip = ctl_in.skip - 3'd1;
            end else begin
                if (sc && hdr == NAL_SPS && !ctl_in.flags[UNIT_SPS]) begin
                    j.ctl.flags[UNIT_SPS] = 1'b1;
                    j.hit[UNIT_SPS]       = 1'b1;
                    j.ctl.skip            = SKIP_AFTER_MATCH;
                    done                  = 1'b1;
                end else if (!ctl_in.flags[UNIT_PPS] && !ctl_in.flags[UNIT_SEI]
                             && ctl_in.flags[UNIT_SPS]) begin
                    j.bump[UNIT_SPS] = 1'b1;
                end
                if (!done) begin
                    if (sc && hdr == NAL_PPS && !ctl_in.flags[UNIT_PPS]) begin
                        j.ctl.flags[UNIT_PPS] = 1'b1;
                        j.hit[UNIT_PPS]       = 1'b1;
                        j.ctl.skip            = SKIP_AFTER_MATCH;
                        done                  = 1'b1;
                    end else if (!ctl_in.flags[UNIT_SEI] && ctl_in.flags[UNIT_PPS]) begin
                        j.bump[UNIT_PPS] = 1'b1;
                    end
                end
                if (!done) begin
                    if (sc && hdr == NAL_SEI && !ctl_in.flags[UNIT_SEI]) begin
                        j.ctl.flags[UNIT_SEI] = 1'b1;
                        j.hit[UNIT_SEI]       = 1'b1;
                        j.ctl.skip            = SKIP_AFTER_MATCH;
                        done                  = 1'b1;
                    end else if (ctl_in.flags[UNIT_SEI]) begin
                        j.bump[UNIT_SEI] = 1'b1;
                    end
                end
                if (!done) begin
                    if (sc && hdr != NAL_SPS && hdr != NAL_PPS && hdr != NAL_SEI) begin
                        j.ctl.flags[UNIT_SLICE] = 1'b1;
                        j.hit[UNIT_SLICE]       = 1'b1;
                        j.ctl.stopped           = 1'b1;
                    end
                end
            end
        end
        return j;
    endfunction

endpackage

@@ hw/rtl/hpss_item_if.sv @@
// Valid/ready channel that carries one input item of the scanner.
interface hpss_item_if;
    import hpss_pkg::*;

    logic  valid;
    logic  ready;
    t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/hpss_result_if.sv @@
// Valid/ready channel that carries one result item of the scanner.
interface hpss_result_if;
    import hpss_pkg::*;

    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/hpss_scan_core.sv @@
// Scan state and combinational next-state logic for one buffer byte or stop item.
module hpss_scan_core #(
    parameter int LENGTH_BITS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  hpss_pkg::t_item  i_item,
    output hpss_pkg::t_result o_result
);
    import hpss_pkg::*;

    localparam int LB = LENGTH_BITS;
    localparam logic [LB-1:0] POS_MAX = '1;

    logic [7:0]    r_window [WIN_DEPTH];
    logic [LB-1:0] r_pos;
    logic [LB-1:0] r_limit;
    t_ctl          r_ctl;
    logic [LB-1:0] r_offsets [NUM_UNITS];
    logic [LB-1:0] r_lengths [NUM_UNITS];
    logic [LB-1:0] r_slice_pos;
    logic          r_recording;

    logic [7:0]    n_window [WIN_DEPTH];
    logic [LB-1:0] n_pos;
    logic [LB-1:0] n_limit;
    t_ctl          n_ctl;
    logic [LB-1:0] n_offsets [NUM_UNITS];
    logic [LB-1:0] n_lengths [NUM_UNITS];
    logic [LB-1:0] n_slice_pos;
    logic          n_recording;

    logic [7:0]    cur_window [WIN_DEPTH];
    logic [LB-1:0] cur_pos;
    logic [LB-1:0] cur_limit;
    t_ctl          cur_ctl;
    logic [LB-1:0] cur_offsets [NUM_UNITS];
    logic [LB-1:0] cur_lengths [NUM_UNITS];
    logic [LB-1:0] cur_slice_pos;

    logic [LB+LEN_IN_BITS-1:0] limit_wide;
    logic [LB:0]   pos_k [NUM_JUDGE];
    logic [LB:0]   q_k [NUM_JUDGE];
    logic          active_k [NUM_JUDGE];
    t_judge        step_j [NUM_JUDGE];
    logic [2:0]    bump_cnt [NUM_UNITS];
    logic          start_code;
    logic          is_byte;

    logic [LB+OUT_BITS-1:0] ext_off [NUM_UNITS];
    logic [LB+OUT_BITS-1:0] ext_len [NUM_UNITS];
    logic [LB+OUT_BITS-1:0] ext_slice;

    assign is_byte = (i_item.operation == OP_BYTE);
    assign limit_wide = {{LB{1'b0}}, 1'b0, i_item.buffer_length[LEN_IN_BITS-1:1]};

    always_comb begin
        if (i_item.first_of_buffer) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                cur_window[i] = SC_ZERO;
            end
            cur_pos   = '0;
            cur_limit = limit_wide[LB-1:0];
            cur_ctl   = '0;
            for (int i = 0; i < NUM_UNITS; i++) begin
                cur_offsets[i] = '0;
                cur_lengths[i] = '0;
            end
            cur_slice_pos = '0;
        end else begin
            cur_window    = r_window;
            cur_pos       = r_pos;
            cur_limit     = r_limit;
            cur_ctl       = r_ctl;
            cur_offsets   = r_offsets;
            cur_lengths   = r_lengths;
            cur_slice_pos = r_slice_pos;
        end
    end

    assign start_code = (cur_window[0] == SC_ZERO) && (cur_window[1] == SC_ZERO)
                        && (cur_window[2] == SC_ZERO) && (cur_window[3] == SC_MARK);

    // Only the position ending at the current byte can hold a full start code; the
    // positions judged at the end of a buffer see absent bytes and never match.
    always_comb begin
        for (int k = 0; k < NUM_JUDGE; k++) begin
            pos_k[k]    = {1'b0, cur_pos} + (LB+1)'(k);
            q_k[k]      = pos_k[k] - (LB+1)'(WIN_DEPTH);
            active_k[k] = (pos_k[k] >= (LB+1)'(WIN_DEPTH)) && (q_k[k] < {1'b0, cur_limit})
                          && ((k == 0) || i_item.last_of_buffer);
        end
        step_j[0] = judge_step(cur_ctl, active_k[0], start_code, i_item.data_byte);
        for (int k = 1; k < NUM_JUDGE; k++) begin
            step_j[k] = judge_step(step_j[k-1].ctl, active_k[k], 1'b0, i_item.data_byte);
        end
        for (int i = 0; i < NUM_UNITS; i++) begin
            bump_cnt[i] = '0;
            for (int k = 0; k < NUM_JUDGE; k++) begin
                bump_cnt[i] = bump_cnt[i] + {2'b00, step_j[k].bump[i]};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            n_window[i] = cur_window[i+1];
        end
        n_window[WIN_DEPTH-1] = i_item.data_byte;
        n_pos   = (cur_pos < POS_MAX) ? cur_pos + LB'(1) : cur_pos;
        n_limit = cur_limit;
        n_ctl   = step_j[NUM_JUDGE-1].ctl;
        if (i_item.last_of_buffer) begin
            n_ctl.stopped = 1'b1;
        end
        for (int i = 0; i < NUM_UNITS; i++) begin
            n_offsets[i] = step_j[0].hit[i] ? cur_pos : cur_offsets[i];
            n_lengths[i] = cur_lengths[i] + LB'(bump_cnt[i]);
        end
        n_slice_pos = step_j[0].hit[UNIT_SLICE] ? q_k[0][LB-1:0] : cur_slice_pos;
        if (!is_byte) begin
            n_recording = 1'b0;
        end else if (i_item.last_of_buffer && n_ctl.flags[UNIT_SPS]) begin
            n_recording = 1'b1;
        end else begin
            n_recording = r_recording;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_limit     <= '0;
            r_ctl       <= '0;
            r_recording <= 1'b0;
        end else if (i_go) begin
            r_recording <= n_recording;
            if (is_byte) begin
                r_pos   <= n_pos;
                r_limit <= n_limit;
                r_ctl   <= n_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && is_byte) begin
            r_window    <= n_window;
            r_offsets   <= n_offsets;
            r_lengths   <= n_lengths;
            r_slice_pos <= n_slice_pos;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_UNITS; i++) begin
            ext_off[i] = {{OUT_BITS{1'b0}}, n_offsets[i]};
            ext_len[i] = {{OUT_BITS{1'b0}}, n_lengths[i]};
        end
        ext_slice = {{OUT_BITS{1'b0}}, n_slice_pos};

        o_result.sps_found  = n_ctl.flags[UNIT_SPS];
        o_result.sps_offset = n_ctl.flags[UNIT_SPS] ? ext_off[UNIT_SPS][OUT_BITS-1:0] : '0;
        o_result.sps_length = n_ctl.flags[UNIT_SPS] ? ext_len[UNIT_SPS][OUT_BITS-1:0] : '0;
        o_result.pps_found  = n_ctl.flags[UNIT_PPS];
        o_result.pps_offset = n_ctl.flags[UNIT_PPS] ? ext_off[UNIT_PPS][OUT_BITS-1:0] : '0;
        o_result.pps_length = n_ctl.flags[UNIT_PPS] ? ext_len[UNIT_PPS][OUT_BITS-1:0] : '0;
        o_result.sei_found  = n_ctl.flags[UNIT_SEI];
        o_result.sei_offset = n_ctl.flags[UNIT_SEI] ? ext_off[UNIT_SEI][OUT_BITS-1:0] : '0;
        o_result.sei_length = n_ctl.flags[UNIT_SEI] ? ext_len[UNIT_SEI][OUT_BITS-1:0] : '0;
        o_result.slice_found  = n_ctl.flags[UNIT_SLICE];
        o_result.slice_offset = n_ctl.flags[UNIT_SLICE] ? ext_slice[OUT_BITS-1:0] : '0;
        o_result.recording    = n_recording;
    end

endmodule

@@ hw/rtl/h264_parameter_set_scanner_unit.sv @@
// Top level of the start code scanner: input register, scan core and result register.
// The last byte of a buffer waits in the input register; its result is then registered in the result register.
// Throughput: one byte or stop item per cycle while the input register is not stalled.
// The input register stalls only while a finished result waits in the result register.
// Reset clears the scan position, limit and control state, the recording flag and both valid bits.
module h264_parameter_set_scanner_unit #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hpss_item_if.sink            i_item,
    hpss_result_if.source        o_result
);
    import hpss_pkg::*;

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;

    t_result core_result;
    logic    has_result;
    logic    out_free;
    logic    go;

    assign has_result = (r_in.operation == OP_BYTE) && r_in.last_of_buffer;
    assign out_free   = !r_out_valid || o_result.ready;
    assign go         = r_in_valid && (!has_result || out_free);

    assign i_item.ready     = !r_in_valid || go;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    hpss_scan_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (r_in),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go && has_result) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
        if (go && has_result) begin
            r_out <= core_result;
        end
    end

endmodule

@@ dv/hpss_scan_checker.sv @@
`timescale 1ns / 1ps
// Checker of the start code scanner: predicts each scan report from the byte transfers and compares.
module hpss_scan_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    hpss_item_if   i_item,
    hpss_result_if i_result,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked
);
    import hpss_pkg::*;

    localparam logic [8:0] NO_BYTE = 9'h100;

    logic [3:0][7:0] prev_bytes;
    logic [19:0]     next_pos;
    logic [19:0]     half_limit;
    logic [2:0]      skip_left;
    logic            scan_over;
    logic [3:0]      unit_seen;
    logic [19:0]     unit_ofs [NUM_UNITS];
    logic [19:0]     unit_len [NUM_UNITS];
    logic [19:0]     stop_ofs;
    logic            rec_flag;

    t_result reports_due [$];
    int      fail_n = 0;
    int      checked_n = 0;

    assign o_fail_count = fail_n;
    assign o_checked    = checked_n;

    function automatic void restart_scan();
        int u;
        prev_bytes = '0;
        next_pos   = '0;
        half_limit = '0;
        skip_left  = '0;
        scan_over  = 1'b0;
        unit_seen  = '0;
        stop_ofs   = '0;
        for (u = 0; u < NUM_UNITS; u++) begin
            unit_ofs[u] = '0;
            unit_len[u] = '0;
        end
    endfunction

    // Bytes q..q+4 are in win[0..4]; bytes past the end of the buffer read as NO_BYTE.
    function automatic void judge_position(logic [20:0] q, logic [4:0][8:0] win);
        logic       sc;
        logic [7:0] hdr;
        if (scan_over || q >= {1'b0, half_limit}) return;
        if (skip_left != 3'd0) begin
            skip_left--;
            return;
        end
        sc  = win[0] == {1'b0, SC_ZERO} && win[1] == {1'b0, SC_ZERO}
              && win[2] == {1'b0, SC_ZERO} && win[3] == {1'b0, SC_MARK} && !win[4][8];
        hdr = win[4][7:0];

        if (sc && hdr == NAL_SPS && !unit_seen[UNIT_SPS]) begin
            unit_seen[UNIT_SPS] = 1'b1;
            unit_ofs[UNIT_SPS]  = q[19:0] + 20'd4;
            skip_left           = SKIP_AFTER_MATCH;
            return;
        end else if (!unit_seen[UNIT_PPS] && !unit_seen[UNIT_SEI] && unit_seen[UNIT_SPS]) begin
            unit_len[UNIT_SPS]++;
        end

        if (sc && hdr == NAL_PPS && !unit_seen[UNIT_PPS]) begin
            unit_seen[UNIT_PPS] = 1'b1;
            unit_ofs[UNIT_PPS]  = q[19:0] + 20'd4;
            skip_left           = SKIP_AFTER_MATCH;
            return;
        end else if (!unit_seen[UNIT_SEI] && unit_seen[UNIT_PPS]) begin
            unit_len[UNIT_PPS]++;
        end

        if (sc && hdr == NAL_SEI && !unit_seen[UNIT_SEI]) begin
            unit_seen[UNIT_SEI] = 1'b1;
            unit_ofs[UNIT_SEI]  = q[19:0] + 20'd4;
            skip_left           = SKIP_AFTER_MATCH;
            return;
        end else if (unit_seen[UNIT_SEI]) begin
            unit_len[UNIT_SEI]++;
        end

        if (sc && hdr != NAL_SPS && hdr != NAL_PPS && hdr != NAL_SEI) begin
            unit_seen[UNIT_SLICE] = 1'b1;
            stop_ofs              = q[19:0];
            scan_over             = 1'b1;
        end
    endfunction

    function automatic void predict_scan_byte(t_item it);
        logic [8:0][8:0] look;
        logic [4:0][8:0] win;
        logic [20:0]     p;
        t_result         r;
        int              k;
        int              j;
        if (it.operation == OP_STOP) begin
            rec_flag = 1'b0;
            return;
        end
        if (it.first_of_buffer) begin
            restart_scan();
            half_limit = it.buffer_length >> 1;
        end
        p = {1'b0, next_pos};
        for (k = 0; k < 4; k++) look[k] = {1'b0, prev_bytes[k]};
        look[4] = {1'b0, it.data_byte};
        for (k = 5; k < 9; k++) look[k] = NO_BYTE;

        // At the last byte the positions still waiting for look-ahead are judged too.
        for (k = 0; k <= (it.last_of_buffer ? 4 : 0); k++) begin
            if (p + 21'(k) >= 21'd4) begin
                for (j = 0; j < 5; j++) win[j] = look[k + j];
                judge_position(p + 21'(k) - 21'd4, win);
            end
        end

        prev_bytes = {it.data_byte, prev_bytes[3:1]};
        if (next_pos != '1) next_pos++;
        if (!it.last_of_buffer) return;

        scan_over = 1'b1;
        if (unit_seen[UNIT_SPS]) rec_flag = 1'b1;
        r.sps_found    = unit_seen[UNIT_SPS];
        r.sps_offset   = unit_ofs[UNIT_SPS];
        r.sps_length   = unit_len[UNIT_SPS];
        r.pps_found    = unit_seen[UNIT_PPS];
        r.pps_offset   = unit_ofs[UNIT_PPS];
        r.pps_length   = unit_len[UNIT_PPS];
        r.sei_found    = unit_seen[UNIT_SEI];
        r.sei_offset   = unit_ofs[UNIT_SEI];
        r.sei_length   = unit_len[UNIT_SEI];
        r.slice_found  = unit_seen[UNIT_SLICE];
        r.slice_offset = stop_ofs;
        r.recording    = rec_flag;
        reports_due.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_n++;
        end
    endfunction

    function automatic void compare_report(t_result got);
        t_result want;
        if (reports_due.size() == 0) begin
            $error("Result transfer with no scan report outstanding");
            fail_n++;
            return;
        end
        want = reports_due.pop_front();
        check_field("sps_found", 20'(want.sps_found), 20'(got.sps_found));
        check_field("sps_offset", want.sps_offset, got.sps_offset);
        check_field("sps_length", want.sps_length, got.sps_length);
        check_field("pps_found", 20'(want.pps_found), 20'(got.pps_found));
        check_field("pps_offset", want.pps_offset, got.pps_offset);
        check_field("pps_length", want.pps_length, got.pps_length);
        check_field("sei_found", 20'(want.sei_found), 20'(got.sei_found));
        check_field("sei_offset", want.sei_offset, got.sei_offset);
        check_field("sei_length", want.sei_length, got.sei_length);
        check_field("slice_found", 20'(want.slice_found), 20'(got.slice_found));
        check_field("slice_offset", want.slice_offset, got.slice_offset);
        check_field("recording", 20'(want.recording), 20'(got.recording));
        checked_n++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_scan();
            rec_flag = 1'b0;
            reports_due.delete();
        end else begin
            if (i_result.valid && i_result.ready) compare_report(i_result.payload);
            if (i_item.valid && i_item.ready) predict_scan_byte(i_item.payload);
        end
        o_pending = reports_due.size();
    end

endmodule

@@ dv/h264_parameter_set_scanner_unit_tb.sv @@
`timescale 1ns / 1ps
// Top of the scanner testbench: clock, reset, byte stimulus, result back-pressure and verdict.
module h264_parameter_set_scanner_unit_tb;
    import hpss_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int MIN_REPORTS = 48;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [7:0] NAL_IDR_SLICE = 8'h65;
    localparam logic [7:0] NAL_NON_IDR = 8'h41;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hpss_item_if   item_ch ();
    hpss_result_if result_ch ();

    int fail_count;
    int pending_count;
    int checked_count;
    int items_sent = 0;
    int lasts_sent = 0;
    int buffers_sent = 0;
    int stops_sent = 0;
    int result_transfers = 0;
    int idle_cycles = 0;
    bit burst_mode = 1'b0;
    bit hold_done = 1'b0;

    logic [7:0] buf_bytes [$];

    always #4 i_clk = ~i_clk;

    h264_parameter_set_scanner_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    hpss_scan_checker scan_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_item byte_item(logic [7:0] b, logic first, logic last,
                                        logic [19:0] blen);
        t_item it;
        it.operation       = OP_BYTE;
        it.data_byte       = b;
        it.first_of_buffer = first;
        it.last_of_buffer  = last;
        it.buffer_length   = blen;
        return it;
    endfunction

    function automatic t_item stop_item();
        t_item it;
        it.operation       = OP_STOP;
        it.data_byte       = 8'($urandom);
        it.first_of_buffer = 1'($urandom);
        it.last_of_buffer  = 1'($urandom);
        it.buffer_length   = 20'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] pick_nal_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return NAL_SPS;
        if (r < 55) return NAL_PPS;
        if (r < 75) return NAL_SEI;
        if (r < 85) return NAL_IDR_SLICE;
        if (r < 90) return NAL_NON_IDR;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_payload_byte();
        return ($urandom_range(0, 3) == 0) ? SC_ZERO : 8'($urandom);
    endfunction

    task automatic send_item(t_item it);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
        if (it.operation == OP_STOP) stops_sent++;
        else if (it.last_of_buffer) lasts_sent++;
    endtask

    task automatic push_start_code();
        buf_bytes.push_back(SC_ZERO);
        buf_bytes.push_back(SC_ZERO);
        buf_bytes.push_back(SC_ZERO);
        buf_bytes.push_back(SC_MARK);
    endtask

    task automatic send_buffer(logic [19:0] blen, bit allow_stop);
        int i;
        int stop_at;
        int n;
        n = buf_bytes.size();
        stop_at = (allow_stop && $urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
        for (i = 0; i < n; i++) begin
            if (i == stop_at) send_item(stop_item());
            send_item(byte_item(buf_bytes[i], i == 0, i == n - 1,
                                (i == 0) ? blen : 20'($urandom)));
        end
        buffers_sent++;
    endtask

    // Mostly well-formed start codes, with some three-byte and five-byte near misses.
    task automatic build_random_buffer();
        int units;
        int style;
        buf_bytes.delete();
        repeat ($urandom_range(0, 3)) buf_bytes.push_back(pick_payload_byte());
        units = $urandom_range(1, 5);
        repeat (units) begin
            style = $urandom_range(0, 9);
            if (style == 0) begin
                buf_bytes.push_back(SC_ZERO);
                buf_bytes.push_back(SC_ZERO);
                buf_bytes.push_back(SC_MARK);
            end else begin
                if (style == 1) buf_bytes.push_back(SC_ZERO);
                push_start_code();
            end
            buf_bytes.push_back(pick_nal_type());
            repeat ($urandom_range(0, 6)) buf_bytes.push_back(pick_payload_byte());
        end
    endtask

    task automatic send_noise();
        int i;
        int n;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
            send_item(byte_item(8'($urandom), 1'b0,
                                (i == n - 1) && ($urandom_range(0, 1) == 1), 20'($urandom)));
        end
    endtask

    initial begin
        int          sel;
        int          n;
        int          random_floor;
        logic [19:0] blen;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes before any first byte scan nothing.
        send_item(byte_item(8'hFF, 1'b0, 1'b0, 20'hFFFFF));
        send_item(byte_item(SC_ZERO, 1'b0, 1'b1, 20'h00000));

        // Every unit type in one buffer whose stated length exceeds the bytes received.
        buf_bytes.delete();
        push_start_code();
        buf_bytes.push_back(NAL_SPS);
        push_start_code();
        buf_bytes.push_back(NAL_PPS);
        push_start_code();
        buf_bytes.push_back(NAL_SEI);
        push_start_code();
        buf_bytes.push_back(NAL_IDR_SLICE);
        send_buffer(20'hFFFFF, 1'b0);

        // Bytes after the last one, a repeated report, then the recording flag cleared.
        send_item(byte_item(8'hA5, 1'b0, 1'b0, 20'hFFFFF));
        send_item(byte_item(8'hFF, 1'b0, 1'b1, 20'h00000));
        send_item(stop_item());
        send_item(byte_item(SC_MARK, 1'b1, 1'b1, 20'h00000));

        random_floor = items_sent + RANDOM_ITEMS;
        while (items_sent < random_floor || lasts_sent < MIN_REPORTS) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 84) begin
                build_random_buffer();
                n = buf_bytes.size();
                sel = $urandom_range(0, 99);
                if (sel < 45) blen = 20'(n);
                else if (sel < 80) blen = 20'(2 * n + $urandom_range(0, 3));
                else if (sel < 90) blen = 20'($urandom_range(0, n));
                else blen = 20'($urandom);
                send_buffer(blen, 1'b1);
            end else if (sel < 92) begin
                send_noise();
            end else if (sel < 96) begin
                send_item(stop_item());
            end else begin
                send_item(byte_item(8'($urandom), 1'b1, 1'b1, 20'($urandom)));
            end
        end
        item_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d transfers in, %0d buffers, %0d stop transfers, %0d reports checked.",
                 items_sent, buffers_sent, stops_sent, checked_count);
        $display("Receiver hold-off applied: %0d, result transfers: %0d.",
                 hold_done, result_transfers);
        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        result_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!hold_done && result_transfers >= 5) begin
                hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
                if (calm_left > 0) calm_left--;
                else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(100, 300);
                else if ($urandom_range(0, 99) < 15) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (result_ch.valid && result_ch.ready) result_transfers++;
        if (!i_rst_n || (item_ch.valid && item_ch.ready)
            || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer.", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

@@ h264_parameter_set_scanner_unit.f @@
hw/rtl/hpss_pkg.sv
hw/rtl/hpss_item_if.sv
hw/rtl/hpss_result_if.sv
hw/rtl/hpss_scan_core.sv
hw/rtl/h264_parameter_set_scanner_unit.sv
dv/hpss_scan_checker.sv
dv/h264_parameter_set_scanner_unit_tb.sv
